### rtl/ksp_pkg.sv
`default_nettype none
package ksp_pkg;

    localparam int KEY_DEPTH_DEF = 64;

    localparam int TIME_W    = 24;
    localparam int POS_W     = 32;
    localparam int IDX_W     = 6;
    localparam int KCNT_W    = 7;
    localparam int TEN_W     = 16;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // divider: dividend covers |g * dt21| < 2^58, divisor is a key time span
    localparam int DVD_W = 58;
    localparam int DVS_W = 24;

    localparam logic [KCNT_W-1:0] KEY_COUNT_RST = 7'd4;
    localparam logic [TEN_W-1:0]  TENSION_RST   = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TENSION   = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_CLAMPED   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NO_RESULT = 2'd2;

    localparam logic [44:0] TANGENT_LIMIT = 45'h100000000000;

    typedef struct packed {
        logic [TIME_W-1:0]       stamp;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } key_entry_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             busy;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

### rtl/keyframe_cardinal_spline_top.sv
`default_nettype none
// Keyframe cardinal spline evaluator.
// Command channel: a beat is taken at a clock edge with start high and busy
// low. kind selects a keyframe load (entry_index, entry_time, entry_x/y/z) or
// a point query at query_time. A load writes the key table in that cycle and
// gives no result; busy stays low. A query with four or more keys in use
// raises busy; every query ends with one beat on pos_x/y/z, segment_index and
// status, marked by done for one cycle. The receiver cannot hold results off;
// done is raised only once busy is low. With fewer than four keys in use the
// answer comes in the cycle after the query is taken. The shared divider, one
// quotient bit per cycle, runs the segment fraction and six tangent scalings;
// the segment search reads one key at a time from the key memory, which has
// one read port.
// Configuration (cfg_we, cfg_index, cfg_data) takes effect at once; write it
// only while idle. Index 0 is key_count, index 1 is tension (Q0.16).
// Reset sets key_count to 4 and tension to one half and idles the sequencer;
// the key table is not cleared, so load every key in use before a query.
module keyframe_cardinal_spline_top #(
    parameter int KEY_DEPTH = ksp_pkg::KEY_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            kind,
    input  wire logic [ksp_pkg::IDX_W-1:0]       entry_index,
    input  wire logic [ksp_pkg::TIME_W-1:0]      entry_time,
    input  wire logic signed [ksp_pkg::POS_W-1:0] entry_x,
    input  wire logic signed [ksp_pkg::POS_W-1:0] entry_y,
    input  wire logic signed [ksp_pkg::POS_W-1:0] entry_z,
    input  wire logic [ksp_pkg::TIME_W-1:0]      query_time,
    output logic                                 done,
    output logic signed [ksp_pkg::POS_W-1:0]     pos_x,
    output logic signed [ksp_pkg::POS_W-1:0]     pos_y,
    output logic signed [ksp_pkg::POS_W-1:0]     pos_z,
    output logic [ksp_pkg::IDX_W-1:0]            segment_index,
    output logic [ksp_pkg::STAT_W-1:0]           status,
    input  wire logic                            cfg_we,
    input  wire logic [ksp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ksp_pkg::CFG_W-1:0]       cfg_data
);

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int NW = $clog2(KEY_DEPTH + 1);
    localparam int CW = (NW > ksp_pkg::KCNT_W) ? NW : ksp_pkg::KCNT_W;
    localparam int TW = ksp_pkg::TIME_W;
    localparam int PW = ksp_pkg::POS_W;
    localparam int MA = 46;
    localparam int MB = 26;
    localparam int MP = MA + MB;
    localparam int HW = 19;
    localparam int AC = 66;

    localparam logic signed [AC-1:0] RES_MAX = AC'(64'sh7FFFFFFF);
    localparam logic signed [AC-1:0] RES_MIN = -AC'(64'sh80000000);

    typedef enum logic [4:0] {
        S_IDLE, S_RD_LO, S_RD_HI, S_CLAMP, S_SRCH_RD, S_SRCH_CMP, S_FIX,
        S_FETCH, S_CHECK, S_SPREP, S_SDIV, S_SQ, S_S2, S_S3, S_HERM,
        T_MUL1, T_MUL2, T_DIV, T_DWAIT, S_BLEND, S_RES
    } state_t;

    // configuration
    logic [ksp_pkg::KCNT_W-1:0] key_count_reg;
    logic [ksp_pkg::TEN_W-1:0]  tension_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= ksp_pkg::KEY_COUNT_RST;
            tension_reg   <= ksp_pkg::TENSION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ksp_pkg::CFG_KEY_COUNT: key_count_reg <= cfg_data[ksp_pkg::KCNT_W-1:0];
                ksp_pkg::CFG_TENSION:   tension_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    state_t                    state_reg;
    logic [CW-1:0]             n_reg;
    logic [TW-1:0]             t_reg;
    logic [TW-1:0]             lo_reg;
    logic [ksp_pkg::STAT_W-1:0] status_reg;
    logic [AW-1:0]             k_reg;
    logic [2:0]                cnt_reg;
    ksp_pkg::key_entry_t       kp_reg [4];
    logic [TW-1:0]             dt21_reg;
    logic [TW-1:0]             dt20_reg;
    logic [TW-1:0]             dt31_reg;
    logic [16:0]               s_reg;
    logic [16:0]               s2_reg;
    logic [16:0]               s3_reg;
    logic signed [HW-1:0]      h_reg [4];
    logic signed [MP-1:0]      prod_reg;
    logic [1:0]                ax_reg;
    logic                      sel_reg;
    logic                      neg_reg;
    logic signed [MA-1:0]      m_reg [2];
    logic signed [AC-1:0]      acc_reg;
    logic signed [PW-1:0]      pos_reg [3];
    logic [ksp_pkg::IDX_W-1:0] seg_reg;
    logic [ksp_pkg::STAT_W-1:0] stat_out_reg;
    logic                      done_reg;

    // key memory
    logic                mem_we;
    logic [AW-1:0]       mem_raddr;
    ksp_pkg::key_entry_t mem_wdata;
    ksp_pkg::key_entry_t mem_rdata;

    assign busy   = state_reg != S_IDLE;
    // loads land only while idle, so a read never meets a write to its entry
    assign mem_we = start && !busy && (kind == ksp_pkg::KIND_LOAD)
                    && (32'(entry_index) < KEY_DEPTH);
    assign mem_wdata = '{stamp: entry_time, x: entry_x, y: entry_y, z: entry_z};

    ksp_mem #(
        .DEPTH (KEY_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(entry_index)),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        case (state_reg)
            S_RD_LO:   mem_raddr = AW'(1);
            S_RD_HI:   mem_raddr = AW'(n_reg - CW'(2));
            S_SRCH_RD: mem_raddr = k_reg + AW'(1);
            S_FETCH:   mem_raddr = k_reg + AW'(cnt_reg[1:0]) - AW'(1);
            default:   mem_raddr = '0;
        endcase
    end

    // divider
    ksp_pkg::div_req_t div_req;
    ksp_pkg::div_rsp_t div_rsp;

    ksp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic [CW-1:0]   n_now;
    logic [TW-1:0]   t1;
    logic            t_le_t1;
    logic [TW-1:0]   t_off;
    logic [MP-1:0]   prod_mag;

    assign n_now    = (CW'(key_count_reg) > CW'(KEY_DEPTH)) ? CW'(KEY_DEPTH)
                                                           : CW'(key_count_reg);
    assign t1       = kp_reg[1].stamp;
    assign t_le_t1  = t_reg <= t1;
    assign t_off    = t_reg - t1;
    assign prod_mag = prod_reg[MP-1] ? MP'(-prod_reg) : MP'(prod_reg);

    always_comb
    begin
        div_req = '0;
        if (state_reg == S_SPREP && !t_le_t1 && t_off < dt21_reg)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = ksp_pkg::DVD_W'({t_off, 16'h0000});
            div_req.divisor  = dt21_reg;
        end
        else if (state_reg == T_DIV)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_mag[ksp_pkg::DVD_W-1:0];
            div_req.divisor  = sel_reg ? dt31_reg : dt20_reg;
        end
    end

    // coordinates of the current axis
    logic signed [PW-1:0] p_ax [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            case (ax_reg)
                2'd0:    p_ax[i] = kp_reg[i].x;
                2'd1:    p_ax[i] = kp_reg[i].y;
                default: p_ax[i] = kp_reg[i].z;
            endcase
        end
    end

    logic signed [PW:0] dp;
    assign dp = sel_reg ? (PW+1)'(p_ax[3]) - (PW+1)'(p_ax[1])
                        : (PW+1)'(p_ax[2]) - (PW+1)'(p_ax[0]);

    // shared multiplier, product registered every cycle
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [MP-1:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = MA'(s_reg);
                mul_b = MB'(s_reg);
            end
            S_S2:
            begin
                mul_a = MA'(prod_reg[32:16]);
                mul_b = MB'(s_reg);
            end
            T_MUL1:
            begin
                mul_a = MA'(dp);
                mul_b = MB'(tension_reg);
            end
            T_MUL2:
            begin
                // floor of (dp * K) / 2^15
                mul_a = MA'(prod_reg >>> 15);
                mul_b = MB'(dt21_reg);
            end
            S_BLEND:
            begin
                case (cnt_reg)
                    3'd0:
                    begin
                        mul_a = MA'(p_ax[1]);
                        mul_b = MB'(h_reg[0]);
                    end
                    3'd1:
                    begin
                        mul_a = m_reg[0];
                        mul_b = MB'(h_reg[1]);
                    end
                    3'd2:
                    begin
                        mul_a = MA'(p_ax[2]);
                        mul_b = MB'(h_reg[2]);
                    end
                    3'd3:
                    begin
                        mul_a = m_reg[1];
                        mul_b = MB'(h_reg[3]);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign mul_p = MP'(mul_a) * MP'(mul_b);

    // Hermite basis
    logic signed [HW-1:0] s1x, s2x, s3x;
    logic signed [HW-1:0] hv [4];

    assign s1x = HW'(s_reg);
    assign s2x = HW'(s2_reg);
    assign s3x = HW'(s3_reg);

    always_comb
    begin
        hv[0] = (s3x <<< 1) - (s2x <<< 1) - s2x + HW'(65536);
        hv[1] = s3x - (s2x <<< 1) + s1x;
        hv[2] = (s2x <<< 1) + s2x - (s3x <<< 1);
        hv[3] = s3x - s2x;
    end

    // tangent magnitude clamp
    logic [44:0]          tan_mag;
    logic signed [MA-1:0] tan_val;

    assign tan_mag = ((|div_rsp.quotient[ksp_pkg::DVD_W-1:45])
                      || (div_rsp.quotient[44] && (|div_rsp.quotient[43:0])))
                     ? ksp_pkg::TANGENT_LIMIT : div_rsp.quotient[44:0];
    assign tan_val = neg_reg ? -MA'(tan_mag) : MA'(tan_mag);

    // result scaling by 2^-16 (floor) and saturation
    logic signed [AC-1:0] res_sh;
    logic signed [PW-1:0] res_sat;

    assign res_sh  = acc_reg >>> 16;
    assign res_sat = (res_sh > RES_MAX) ? PW'(RES_MAX)
                   : (res_sh < RES_MIN) ? PW'(RES_MIN) : PW'(res_sh);

    logic [TW-1:0] kt0, kt2, kt3;
    assign kt0 = kp_reg[0].stamp;
    assign kt2 = kp_reg[2].stamp;
    assign kt3 = kp_reg[3].stamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            n_reg        <= '0;
            t_reg        <= '0;
            lo_reg       <= '0;
            status_reg   <= ksp_pkg::STATUS_OK;
            k_reg        <= '0;
            cnt_reg      <= '0;
            for (int i = 0; i < 4; i++)
            begin
                kp_reg[i] <= '0;
                h_reg[i]  <= '0;
            end
            dt21_reg     <= '0;
            dt20_reg     <= '0;
            dt31_reg     <= '0;
            s_reg        <= '0;
            s2_reg       <= '0;
            s3_reg       <= '0;
            prod_reg     <= '0;
            ax_reg       <= '0;
            sel_reg      <= 1'b0;
            neg_reg      <= 1'b0;
            m_reg[0]     <= '0;
            m_reg[1]     <= '0;
            acc_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
            end
            seg_reg      <= '0;
            stat_out_reg <= ksp_pkg::STATUS_OK;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_p;
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && kind == ksp_pkg::KIND_QUERY)
                    begin
                        t_reg      <= query_time;
                        status_reg <= ksp_pkg::STATUS_OK;
                        n_reg      <= n_now;
                        if (n_now < CW'(4))
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                pos_reg[i] <= '0;
                            end
                            seg_reg      <= ksp_pkg::IDX_W'(1);
                            stat_out_reg <= ksp_pkg::STATUS_NO_RESULT;
                            done_reg     <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_RD_LO;
                        end
                    end
                end
                S_RD_LO:
                begin
                    state_reg <= S_RD_HI;
                end
                S_RD_HI:
                begin
                    lo_reg    <= mem_rdata.stamp;
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    if (t_reg < lo_reg)
                    begin
                        t_reg      <= lo_reg;
                        status_reg <= ksp_pkg::STATUS_CLAMPED;
                    end
                    else if (t_reg > mem_rdata.stamp)
                    begin
                        t_reg      <= mem_rdata.stamp;
                        status_reg <= ksp_pkg::STATUS_CLAMPED;
                    end
                    k_reg     <= '0;
                    state_reg <= S_SRCH_RD;
                end
                S_SRCH_RD:
                begin
                    if (CW'(k_reg) >= n_reg - CW'(3))
                    begin
                        state_reg <= S_FIX;
                    end
                    else
                    begin
                        state_reg <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP:
                begin
                    if (mem_rdata.stamp < t_reg)
                    begin
                        k_reg     <= k_reg + AW'(1);
                        state_reg <= S_SRCH_RD;
                    end
                    else
                    begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    if (k_reg == '0)
                    begin
                        k_reg <= AW'(1);
                    end
                    cnt_reg   <= '0;
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    // read k-1 .. k+2, each beat of data arriving in the cycle after its address
                    if (cnt_reg != 3'd0)
                    begin
                        kp_reg[2'(cnt_reg - 3'd1)] <= mem_rdata;
                    end
                    if (cnt_reg == 3'd4)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_CHECK:
                begin
                    if (kt2 <= t1 || kt2 <= kt0 || kt3 <= t1)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            pos_reg[i] <= '0;
                        end
                        seg_reg      <= ksp_pkg::IDX_W'(k_reg);
                        stat_out_reg <= ksp_pkg::STATUS_NO_RESULT;
                        done_reg     <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        dt21_reg  <= kt2 - t1;
                        dt20_reg  <= kt2 - kt0;
                        dt31_reg  <= kt3 - t1;
                        state_reg <= S_SPREP;
                    end
                end
                S_SPREP:
                begin
                    if (t_le_t1)
                    begin
                        s_reg     <= '0;
                        state_reg <= S_SQ;
                    end
                    else if (t_off >= dt21_reg)
                    begin
                        s_reg     <= 17'h10000;
                        state_reg <= S_SQ;
                    end
                    else
                    begin
                        state_reg <= S_SDIV;
                    end
                end
                S_SDIV:
                begin
                    if (div_rsp.done)
                    begin
                        s_reg     <= div_rsp.quotient[16:0];
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_S2;
                end
                S_S2:
                begin
                    s2_reg    <= prod_reg[32:16];
                    state_reg <= S_S3;
                end
                S_S3:
                begin
                    s3_reg    <= prod_reg[32:16];
                    state_reg <= S_HERM;
                end
                S_HERM:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        h_reg[i] <= hv[i];
                    end
                    ax_reg    <= '0;
                    sel_reg   <= 1'b0;
                    state_reg <= T_MUL1;
                end
                T_MUL1:
                begin
                    state_reg <= T_MUL2;
                end
                T_MUL2:
                begin
                    state_reg <= T_DIV;
                end
                T_DIV:
                begin
                    neg_reg   <= prod_reg[MP-1];
                    state_reg <= T_DWAIT;
                end
                T_DWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        m_reg[sel_reg] <= tan_val;
                        if (!sel_reg)
                        begin
                            sel_reg   <= 1'b1;
                            state_reg <= T_MUL1;
                        end
                        else
                        begin
                            cnt_reg   <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_BLEND;
                        end
                    end
                end
                S_BLEND:
                begin
                    if (cnt_reg != 3'd0)
                    begin
                        acc_reg <= acc_reg + AC'(prod_reg);
                    end
                    if (cnt_reg == 3'd4)
                    begin
                        state_reg <= S_RES;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_RES:
                begin
                    pos_reg[ax_reg] <= res_sat;
                    if (ax_reg == 2'd2)
                    begin
                        seg_reg      <= ksp_pkg::IDX_W'(k_reg);
                        stat_out_reg <= status_reg;
                        done_reg     <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        sel_reg   <= 1'b0;
                        state_reg <= T_MUL1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign pos_x         = pos_reg[0];
    assign pos_y         = pos_reg[1];
    assign pos_z         = pos_reg[2];
    assign segment_index = seg_reg;
    assign status        = stat_out_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while a query is still in flight");

    a_short_table: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && kind == ksp_pkg::KIND_QUERY && n_now < CW'(4) |=>
        done && status == ksp_pkg::STATUS_NO_RESULT)
        else $error("short key table did not answer at once");

    a_segment_floor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> segment_index != '0)
        else $error("segment index below one");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_no_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ksp_pkg::STATUS_NO_RESULT |->
        pos_x == '0 && pos_y == '0 && pos_z == '0)
        else $error("rejected query carries a position");

endmodule
`default_nettype wire

### rtl/ksp_mem.sv
`default_nettype none
module ksp_mem #(
    parameter int DEPTH = ksp_pkg::KEY_DEPTH_DEF,
    parameter int AW    = $clog2(ksp_pkg::KEY_DEPTH_DEF)
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire ksp_pkg::key_entry_t wdata,
    input  wire logic [AW-1:0]       raddr,
    output ksp_pkg::key_entry_t      rdata
);

    ksp_pkg::key_entry_t key_mem [DEPTH];
    ksp_pkg::key_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wdata;
        end
        rdata_reg <= key_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/ksp_div.sv
`default_nettype none
module ksp_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ksp_pkg::div_req_t req,
    output ksp_pkg::div_rsp_t      rsp
);

    localparam int DW    = ksp_pkg::DVD_W;
    localparam int SW    = ksp_pkg::DVS_W;
    localparam int CNT_W = $clog2(ksp_pkg::DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    dvd_reg;
    logic [SW-1:0]    dvs_reg;
    logic [SW-1:0]    rem_reg;

    logic [SW:0]   rem_sh;
    logic [SW-1:0] diff;
    logic          ge;

    // one quotient bit per cycle, restoring
    assign rem_sh = {rem_reg, dvd_reg[DW-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};
    // when ge holds the difference is below the divisor, so the low bits suffice
    assign diff   = rem_sh[SW-1:0] - dvs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DW);
            dvd_reg  <= req.dividend;
            dvs_reg  <= req.divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], ge};
            rem_reg <= ge ? diff : rem_sh[SW-1:0];
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = dvd_reg;

endmodule
`default_nettype wire
